@@ hdl/tfrb_pkg.sv @@
`default_nettype none

package tfrb_pkg;

    localparam int WORD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int TAG_BYTES = 4;
    localparam int NUM_WORDS = 6;   // word ports on the input channel
    localparam int CNT_IN_W  = 3;
    localparam int LEN_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 9;

    localparam logic [WORD_W-1:0] TAG_RESET = 32'h6372_7368;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_GIVEN  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // register index of frame_tag
    localparam logic REG_FRAME_TAG = 1'b0;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_IDX_W = 1;

    typedef struct packed {
        logic             is_pop;
        logic [LEN_W-1:0] len;      // frame length in bytes, tag included
    } t_cmd_ctl;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    frame_bytes;
        logic [BYTE_W-1:0]   tx_byte;
        logic [FILL_W-1:0]   fill_level;
    } t_out_item;

endpackage

`default_nettype wire

@@ hdl/tfrb_if.sv @@
`default_nettype none

interface tfrb_in_if import tfrb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                command;
    logic [CNT_IN_W-1:0] word_count;
    logic [WORD_W-1:0]   word_0;
    logic [WORD_W-1:0]   word_1;
    logic [WORD_W-1:0]   word_2;
    logic [WORD_W-1:0]   word_3;
    logic [WORD_W-1:0]   word_4;
    logic [WORD_W-1:0]   word_5;

    modport source (
        output valid, command, word_count,
        output word_0, word_1, word_2, word_3, word_4, word_5,
        input  ready
    );
    modport sink (
        input  valid, command, word_count,
        input  word_0, word_1, word_2, word_3, word_4, word_5,
        output ready
    );
endinterface

interface tfrb_out_if import tfrb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    frame_bytes;
    logic [BYTE_W-1:0]   tx_byte;
    logic [FILL_W-1:0]   fill_level;

    modport source (
        output valid, status, frame_bytes, tx_byte, fill_level,
        input  ready
    );
    modport sink (
        input  valid, status, frame_bytes, tx_byte, fill_level,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/tfrb_front.sv @@
`default_nettype none

module tfrb_front import tfrb_pkg::*; #(
    parameter int MAX_WORDS = 6
) (
    tfrb_in_if.sink                  i_in,
    input  wire logic                i_q_full,
    output logic                     o_q_push,
    output t_cmd_ctl                 o_q_ctl,
    output logic [MAX_WORDS*WORD_W-1:0] o_q_words
);

    localparam logic [CNT_IN_W-1:0] MAX_N = CNT_IN_W'(MAX_WORDS);

    logic [CNT_IN_W-1:0] w_n;
    logic [WORD_W-1:0]   w_word [NUM_WORDS];

    assign i_in.ready = !i_q_full;
    assign o_q_push   = i_in.valid && !i_q_full;

    // oversize word counts clamp to the largest frame
    assign w_n = (i_in.word_count > MAX_N) ? MAX_N : i_in.word_count;

    assign o_q_ctl.is_pop = (i_in.command == CMD_POP);
    assign o_q_ctl.len    = LEN_W'(TAG_BYTES) + {w_n, 2'b00};

    assign w_word[0] = i_in.word_0;
    assign w_word[1] = i_in.word_1;
    assign w_word[2] = i_in.word_2;
    assign w_word[3] = i_in.word_3;
    assign w_word[4] = i_in.word_4;
    assign w_word[5] = i_in.word_5;

    always_comb begin
        for (int k = 0; k < MAX_WORDS; k++) begin
            o_q_words[k*WORD_W +: WORD_W] = w_word[k];
        end
    end

endmodule

`default_nettype wire

@@ hdl/tfrb_queue.sv @@
`default_nettype none

module tfrb_queue import tfrb_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wr_idx;
    logic [Q_IDX_W-1:0] r_rd_idx;
    logic [Q_IDX_W:0]   r_count;

    assign o_full  = (r_count == (Q_IDX_W+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_idx <= r_wr_idx + 1'b1;
            if (i_pop)  r_rd_idx <= r_rd_idx + 1'b1;
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_idx] <= i_data;
    end

endmodule

`default_nettype wire

@@ hdl/tfrb_back.sv @@
`default_nettype none

module tfrb_back import tfrb_pkg::*; #(
    parameter int RING_DEPTH = 256,
    parameter int MAX_WORDS  = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [WORD_W-1:0]          i_frame_tag,
    input  wire logic                       i_q_valid,
    input  wire t_cmd_ctl                   i_q_ctl,
    input  wire logic [MAX_WORDS*WORD_W-1:0] i_q_words,
    output logic                            o_q_pop,
    tfrb_out_if.source                      o_out
);

    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int FRAME_W = (TAG_BYTES + 4*MAX_WORDS) * BYTE_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WRITE = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_byte_count, n_byte_count;
    logic [LEN_W-1:0]   r_byte_idx, n_byte_idx;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [BYTE_W-1:0]  r_ring [RING_DEPTH];
    logic [BYTE_W-1:0]  r_rd_data;

    logic               w_take;
    logic               w_fits;
    logic               w_last;
    logic [FRAME_W-1:0] w_shifted;
    logic [BYTE_W-1:0]  w_wr_byte;
    logic [CNT_W-1:0]   w_cnt_inc;
    logic [CNT_W-1:0]   w_cnt_dec;

    // truncate or zero-extend a count to the fill field
    function automatic logic [FILL_W-1:0] to_fill(input logic [CNT_W-1:0] c);
        logic [CNT_W+FILL_W-1:0] ext;
        ext = {{FILL_W{1'b0}}, c};
        return ext[FILL_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_take  = (r_state == S_IDLE) && i_q_valid && !r_out_valid;
    assign o_q_pop = w_take;

    assign w_fits = ({1'b0, r_byte_count} + (CNT_W+1)'(i_q_ctl.len))
                    <= (CNT_W+1)'(RING_DEPTH);

    assign w_last    = (r_byte_idx == r_len - 1'b1);
    assign w_shifted = r_frame >> {r_byte_idx, 3'b000};
    assign w_wr_byte = w_shifted[BYTE_W-1:0];
    assign w_cnt_inc = r_byte_count + CNT_W'(r_len);
    assign w_cnt_dec = r_byte_count - 1'b1;

    always_comb begin
        n_state      = r_state;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_byte_count = r_byte_count;
        n_byte_idx   = r_byte_idx;
        n_len        = r_len;
        n_frame      = r_frame;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_out.ready;

        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (!i_q_ctl.is_pop) begin
                        if (w_fits) begin
                            n_frame    = {i_q_words, i_frame_tag};
                            n_len      = i_q_ctl.len;
                            n_byte_idx = '0;
                            n_state    = S_WRITE;
                        end else begin
                            n_out       = '{ST_REJECT, '0, '0, to_fill(r_byte_count)};
                            n_out_valid = 1'b1;
                        end
                    end else if (r_byte_count == '0) begin
                        n_out       = '{ST_EMPTY, '0, '0, '0};
                        n_out_valid = 1'b1;
                    end else begin
                        // ring read issued this cycle, data next cycle
                        n_state = S_READ;
                    end
                end
            end
            S_WRITE: begin
                n_wr_ptr   = adv(r_wr_ptr);
                n_byte_idx = r_byte_idx + 1'b1;
                if (w_last) begin
                    n_byte_count = w_cnt_inc;
                    n_out        = '{ST_ACCEPT, r_len, '0, to_fill(w_cnt_inc)};
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_READ: begin
                n_rd_ptr     = adv(r_rd_ptr);
                n_byte_count = w_cnt_dec;
                n_out        = '{ST_GIVEN, '0, r_rd_data, to_fill(w_cnt_dec)};
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_byte_count <= '0;
            r_byte_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wr_ptr     <= n_wr_ptr;
            r_rd_ptr     <= n_rd_ptr;
            r_byte_count <= n_byte_count;
            r_byte_idx   <= n_byte_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_frame <= n_frame;
        r_out   <= n_out;
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) r_ring[r_wr_ptr] <= w_wr_byte;
        r_rd_data <= r_ring[r_rd_ptr];
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out.status;
    assign o_out.frame_bytes = r_out.frame_bytes;
    assign o_out.tx_byte     = r_out.tx_byte;
    assign o_out.fill_level  = r_out.fill_level;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CNT_W'(RING_DEPTH))
        else $error("fill count above ring depth");

    a_write_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> !r_out_valid)
        else $error("frame write with a result still pending");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_out_valid && r_out.status == ST_GIVEN))
        else $error("ring read did not produce a byte result");

    a_push_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && w_last) |=>
        (r_out_valid && r_out.status == ST_ACCEPT && r_out.frame_bytes == $past(r_len)))
        else $error("frame write end without matching accept result");

endmodule

`default_nettype wire

@@ hdl/tagged_frame_tx_ring_buffer_unit.sv @@
// A push of n words writes its 4 + 4n bytes in S_WRITE, one ring byte per cycle, and
//   posts its result with the last; a rejected push or an empty-ring pop posts one from
//   S_IDLE; a byte pop passes S_READ. The back end takes a command only in S_IDLE with
//   its result slot empty; the ring write port sets the push cost. A two-entry command
//   queue takes transfers while not full. Reset (synchronous, active low) clears pointers,
//   fill count and queue, loads frame_tag with "hsrc"; ring contents are kept.
`default_nettype none

module tagged_frame_tx_ring_buffer_unit import tfrb_pkg::*; #(
    parameter int RING_DEPTH = 256,
    parameter int MAX_WORDS  = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command channel
    tfrb_in_if.sink                i_in,
    // result channel
    tfrb_out_if.source             o_out,
    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0]      prdata,
    output logic                   pready
);

    localparam int Q_W = $bits(t_cmd_ctl) + MAX_WORDS*WORD_W;

    logic [WORD_W-1:0] r_frame_tag;
    logic              w_reg_sel;

    logic                        w_q_push;
    logic                        w_q_full;
    t_cmd_ctl                    w_front_ctl;
    logic [MAX_WORDS*WORD_W-1:0] w_front_words;
    logic                        w_q_valid;
    logic                        w_q_pop;
    logic [Q_W-1:0]              w_q_data;
    t_cmd_ctl                    w_back_ctl;
    logic [MAX_WORDS*WORD_W-1:0] w_back_words;

    // ------------------------------------------------------------------
    // Register port: one register, frame_tag, at byte address 0.
    // Zero wait states; write lands in the access phase.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2] == REG_FRAME_TAG);
    assign prdata    = w_reg_sel ? r_frame_tag : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_tag <= TAG_RESET;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_frame_tag <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Front: classify each transfer (push/pop, clamp word count, frame
    // length) and drop it into the command queue.
    // ------------------------------------------------------------------
    tfrb_front #(
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .i_in      (i_in),
        .i_q_full  (w_q_full),
        .o_q_push  (w_q_push),
        .o_q_ctl   (w_front_ctl),
        .o_q_words (w_front_words)
    );

    tfrb_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  ({w_front_ctl, w_front_words}),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_back_ctl   = w_q_data[Q_W-1 -: $bits(t_cmd_ctl)];
    assign w_back_words = w_q_data[MAX_WORDS*WORD_W-1:0];

    // ------------------------------------------------------------------
    // Back: room check, byte-serial frame write into the ring, byte
    // reads, and the registered result slot.
    // ------------------------------------------------------------------
    tfrb_back #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_WORDS  (MAX_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame_tag (r_frame_tag),
        .i_q_valid   (w_q_valid),
        .i_q_ctl     (w_back_ctl),
        .i_q_words   (w_back_words),
        .o_q_pop     (w_q_pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ sim/tb_tagged_frame_tx_ring_buffer_unit.sv @@
`timescale 1ns / 1ps

module tb_tagged_frame_tx_ring_buffer_unit;
    import tfrb_pkg::*;

    localparam int RING_DEPTH  = 256;
    localparam int MAX_WORDS   = 6;
    localparam int N_DIRECTED  = 18;
    localparam int N_PHASES    = 4;
    localparam int PHASE_ITEMS = 233;        // 4 x 233 random + 18 directed ~ 950
    localparam int HOLD_CYCLES = 400;        // long receiver hold-off
    localparam int DRAIN_WAIT  = 40;         // outlasts the longest push
    localparam int CYCLE_LIMIT = 400_000;

    localparam logic [2:0] TAG_ADDR = 3'(4 * REG_FRAME_TAG);

    // one command as offered on the input channel
    typedef struct packed {
        logic                              cmd;
        logic [CNT_IN_W-1:0]               wcnt;
        logic [NUM_WORDS-1:0][WORD_W-1:0]  words;
    } t_ring_cmd;

    // directed table row: command plus an optional hand-typed result
    typedef struct packed {
        t_ring_cmd c;
        logic      typed;
        t_out_item res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    // register port
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [WORD_W-1:0] pwdata;
    logic [WORD_W-1:0] prdata;
    logic              pready;

    tfrb_in_if  cmd_ch ();
    tfrb_out_if res_ch ();

    tagged_frame_tx_ring_buffer_unit #(
        .RING_DEPTH(RING_DEPTH),
        .MAX_WORDS (MAX_WORDS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch),
        .o_out  (res_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ---------------------------------------------------------------
    // Ring predictor state: mirrors the block after reset
    // ---------------------------------------------------------------
    logic [7:0]        ring_mem [RING_DEPTH];
    logic [7:0]        wr_ptr;
    logic [7:0]        rd_ptr;
    int unsigned       fill_cnt;
    logic [WORD_W-1:0] tag_reg;

    t_out_item pending_results [$];   // expected results, oldest first

    // run control shared by sender and receiver
    bit idle_en;      // random gaps allowed on both sides
    bit hold_req;     // ask receiver for one long hold-off

    int n_err;
    int n_tag_err;
    int n_items;
    int n_stored;
    int n_rejected;
    int n_given;
    int n_empty;
    int peak_fill;
    int cycles;

    t_dir_row dir_rows [N_DIRECTED];

    // Predict the result of one command and advance the ring state.
    // Frame = 4 tag bytes, then each word low byte first.
    function automatic t_out_item predict_ring_result(input t_ring_cmd c);
        t_out_item   r;
        int unsigned n;
        int unsigned len;
        r = '0;
        if (c.cmd == CMD_PUSH) begin
            n   = (c.wcnt > MAX_WORDS) ? MAX_WORDS : c.wcnt;   // oversize count clamps
            len = TAG_BYTES + 4 * n;
            if (fill_cnt + len > RING_DEPTH) begin
                r.status = ST_REJECT;                           // nothing written
            end else begin
                for (int i = 0; i < TAG_BYTES; i++) begin
                    ring_mem[wr_ptr] = tag_reg[8*i +: 8];
                    wr_ptr++;
                end
                for (int k = 0; k < n; k++) begin
                    for (int i = 0; i < 4; i++) begin
                        ring_mem[wr_ptr] = c.words[k][8*i +: 8];
                        wr_ptr++;
                    end
                end
                fill_cnt      += len;
                r.status      = ST_ACCEPT;
                r.frame_bytes = LEN_W'(len);
            end
        end else if (fill_cnt == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.tx_byte = ring_mem[rd_ptr];
            rd_ptr++;
            fill_cnt--;
            r.status = ST_GIVEN;
        end
        r.fill_level = FILL_W'(fill_cnt);
        if (fill_cnt > peak_fill)
            peak_fill = fill_cnt;
        return r;
    endfunction

    // Directed row; words are the seed rotated by 4 bits per word, so
    // all-zero and all-one seeds stay extreme in every word.
    function automatic t_dir_row mk_row(input logic cmd, input logic [2:0] wc,
                                        input logic [31:0] seed, input logic typed,
                                        input logic [STATUS_W-1:0] st,
                                        input logic [LEN_W-1:0] fb,
                                        input logic [7:0] tb,
                                        input logic [FILL_W-1:0] fl);
        t_dir_row    d;
        logic [63:0] dbl;
        dbl    = {seed, seed};
        d.c.cmd  = cmd;
        d.c.wcnt = wc;
        for (int k = 0; k < NUM_WORDS; k++)
            d.c.words[k] = dbl[4*k +: 32];
        d.typed           = typed;
        d.res.status      = st;
        d.res.frame_bytes = fb;
        d.res.tx_byte     = tb;
        d.res.fill_level  = fl;
        return d;
    endfunction

    // Random command; pushes come with probability push_pct percent.
    function automatic t_ring_cmd rand_cmd(input int push_pct);
        t_ring_cmd c;
        c.cmd  = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        c.wcnt = CNT_IN_W'($urandom_range(0, 7));
        for (int k = 0; k < NUM_WORDS; k++) begin
            case ($urandom_range(0, 7))
                0:       c.words[k] = '0;
                1:       c.words[k] = '1;
                default: c.words[k] = $urandom;
            endcase
        end
        return c;
    endfunction

    // Offer one command and wait for the transfer. valid stays high on
    // return so back-to-back commands need no extra step.
    task automatic send_cmd(input t_ring_cmd c, input logic typed,
                            input t_out_item typed_res);
        t_out_item r;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= c.cmd;
        cmd_ch.word_count <= c.wcnt;
        cmd_ch.word_0     <= c.words[0];
        cmd_ch.word_1     <= c.words[1];
        cmd_ch.word_2     <= c.words[2];
        cmd_ch.word_3     <= c.words[3];
        cmd_ch.word_4     <= c.words[4];
        cmd_ch.word_5     <= c.words[5];
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        // transfer happened at this edge
        r = predict_ring_result(c);
        pending_results.push_back(typed ? typed_res : r);
        n_items++;
        case (r.status)
            ST_ACCEPT: n_stored++;
            ST_REJECT: n_rejected++;
            ST_GIVEN:  n_given++;
            default:   n_empty++;
        endcase
    endtask

    // Stop offering and wait until every expected result has been taken.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // APB write of frame_tag: setup then access, pready honored.
    task automatic write_frame_tag(input logic [WORD_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TAG_ADDR;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tag_reg = v;
    endtask

    // APB read of frame_tag, compared with the predictor's copy.
    task automatic check_tag_readback();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TAG_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== tag_reg) begin
            n_tag_err++;
            if (n_err + n_tag_err <= 10)
                $display("frame_tag read mismatch: expected %h actual %h", tag_reg, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result checker: each transfer against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                n_err++;
                if (n_err + n_tag_err <= 10)
                    $display("unexpected result: status %0d bytes %0d tx %h fill %0d",
                             res_ch.status, res_ch.frame_bytes, res_ch.tx_byte,
                             res_ch.fill_level);
            end else begin
                want = pending_results.pop_front();
                if (res_ch.status !== want.status ||
                    res_ch.frame_bytes !== want.frame_bytes ||
                    res_ch.tx_byte !== want.tx_byte ||
                    res_ch.fill_level !== want.fill_level) begin
                    n_err++;
                    if (n_err + n_tag_err <= 10)
                        $display({"result mismatch: expected st %0d len %0d tx %h fill %0d,",
                                  " actual st %0d len %0d tx %h fill %0d"},
                                 want.status, want.frame_bytes, want.tx_byte,
                                 want.fill_level, res_ch.status, res_ch.frame_bytes,
                                 res_ch.tx_byte, res_ch.fill_level);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                // sender keeps offering; command queue and output fill up
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("** tagged_frame_tx_ring_buffer_unit: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        logic [WORD_W-1:0] phase_tag [N_PHASES];
        int                push_pct;

        // every block input known from time zero
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.command    <= CMD_PUSH;
        cmd_ch.word_count <= '0;
        cmd_ch.word_0     <= '0;
        cmd_ch.word_1     <= '0;
        cmd_ch.word_2     <= '0;
        cmd_ch.word_3     <= '0;
        cmd_ch.word_4     <= '0;
        cmd_ch.word_5     <= '0;

        n_items    = 0;
        n_stored   = 0;
        n_rejected = 0;
        n_given    = 0;
        n_empty    = 0;
        peak_fill  = 0;
        wr_ptr     = '0;
        rd_ptr     = '0;
        fill_cnt   = 0;
        tag_reg    = TAG_RESET;
        idle_en    = 1'b1;
        hold_req   = 1'b0;

        // Directed part. Pushes climb to 252 bytes, then: no room,
        // exact fit to 256, no room when full, and pops of the first
        // tag bytes ("h", "s"). Pop rows carry junk push fields.
        dir_rows = '{
            mk_row(CMD_POP,  3'd7, 32'hFFFF_FFFF, 1'b1, ST_EMPTY,  5'd0,  8'h00, 9'd0),
            mk_row(CMD_PUSH, 3'd0, 32'h1234_5678, 1'b1, ST_ACCEPT, 5'd4,  8'h00, 9'd4),
            mk_row(CMD_PUSH, 3'd7, 32'hFFFF_FFFF, 1'b1, ST_ACCEPT, 5'd28, 8'h00, 9'd32),
            mk_row(CMD_PUSH, 3'd1, 32'h8000_0001, 1'b0, ST_ACCEPT, 5'd0,  8'h00, 9'd0),
            mk_row(CMD_PUSH, 3'd2, 32'h7FFF_FFFE, 1'b0, ST_ACCEPT, 5'd0,  8'h00, 9'd0),
            mk_row(CMD_PUSH, 3'd3, 32'hA5A5_5A5A, 1'b0, ST_ACCEPT, 5'd0,  8'h00, 9'd0),
            mk_row(CMD_PUSH, 3'd4, 32'h0F1E_2D3C, 1'b0, ST_ACCEPT, 5'd0,  8'h00, 9'd0),
            mk_row(CMD_PUSH, 3'd5, 32'hC3D2_E1F0, 1'b0, ST_ACCEPT, 5'd0,  8'h00, 9'd0),
            mk_row(CMD_PUSH, 3'd6, 32'h0000_0000, 1'b0, ST_ACCEPT, 5'd0,  8'h00, 9'd0),
            mk_row(CMD_PUSH, 3'd6, 32'h0123_4567, 1'b0, ST_ACCEPT, 5'd0,  8'h00, 9'd0),
            mk_row(CMD_PUSH, 3'd6, 32'h89AB_CDEF, 1'b0, ST_ACCEPT, 5'd0,  8'h00, 9'd0),
            mk_row(CMD_PUSH, 3'd6, 32'h5555_AAAA, 1'b0, ST_ACCEPT, 5'd0,  8'h00, 9'd0),
            mk_row(CMD_PUSH, 3'd6, 32'h3F80_0000, 1'b0, ST_ACCEPT, 5'd0,  8'h00, 9'd0),
            mk_row(CMD_PUSH, 3'd1, 32'hFFFF_0000, 1'b1, ST_REJECT, 5'd0,  8'h00, 9'd252),
            mk_row(CMD_PUSH, 3'd0, 32'h0000_0000, 1'b1, ST_ACCEPT, 5'd4,  8'h00, 9'd256),
            mk_row(CMD_PUSH, 3'd0, 32'h0000_0000, 1'b1, ST_REJECT, 5'd0,  8'h00, 9'd256),
            mk_row(CMD_POP,  3'd7, 32'hFFFF_FFFF, 1'b1, ST_GIVEN,  5'd0,  8'h68, 9'd255),
            mk_row(CMD_POP,  3'd0, 32'h0000_0000, 1'b1, ST_GIVEN,  5'd0,  8'h73, 9'd254)
        };

        // tag extremes first, then two random settings
        phase_tag[0] = 32'hFFFF_FFFF;
        phase_tag[1] = 32'h0000_0000;
        phase_tag[2] = $urandom;
        phase_tag[3] = $urandom;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_tag_readback();       // reset value "hsrc"

        for (int i = 0; i < N_DIRECTED; i++)
            send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        // Random phases, one tag setting each. Blocks of 40 commands pick
        // a push rate: drain (3%), balanced (6%), fill (20%), full (40%),
        // so the fill walks from empty through wrap-around to full.
        for (int p = 0; p < N_PHASES; p++) begin
            write_frame_tag(phase_tag[p]);
            check_tag_readback();
            if (p == 1)
                hold_req = 1'b1;                // long receiver hold-off
            if (p == N_PHASES - 1)
                idle_en = 1'b0;                 // last part at full rate
            push_pct = 6;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 40 == 0) begin
                    case ($urandom_range(0, 3))
                        0:       push_pct = 3;
                        1:       push_pct = 6;
                        2:       push_pct = 20;
                        default: push_pct = 40;
                    endcase
                end
                send_cmd(rand_cmd(push_pct), 1'b0, '0);
            end
            drain_results();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("ran %0d commands over %0d tag settings: %0d frames stored, %0d refused",
                 n_items, N_PHASES + 1, n_stored, n_rejected);
        $display("%0d bytes popped, %0d pops on empty ring, peak fill %0d of %0d",
                 n_given, n_empty, peak_fill, RING_DEPTH);
        if (n_err + n_tag_err == 0 && pending_results.size() == 0) begin
            $display("** tagged_frame_tx_ring_buffer_unit: PASSED **");
        end else begin
            $display("%0d errors, %0d results missing", n_err + n_tag_err,
                     pending_results.size());
            $display("** tagged_frame_tx_ring_buffer_unit: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/tfrb_pkg.sv
hdl/tfrb_if.sv
hdl/tfrb_front.sv
hdl/tfrb_queue.sv
hdl/tfrb_back.sv
hdl/tagged_frame_tx_ring_buffer_unit.sv
sim/tb_tagged_frame_tx_ring_buffer_unit.sv
